// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== design/rv64d_pkg.sv =====
// Types and constants of the RV64I instruction decoder.
package rv64d_pkg;

   localparam int InstrWidth = 32;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_COMPACT = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_UNDEF   = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      OP_INVALID   = 6'd0,
      OP_LB        = 6'd1,
      OP_LH        = 6'd2,
      OP_LW        = 6'd3,
      OP_LD        = 6'd4,
      OP_LBU       = 6'd5,
      OP_LHU       = 6'd6,
      OP_LWU       = 6'd7,
      OP_SB        = 6'd8,
      OP_SH        = 6'd9,
      OP_SW        = 6'd10,
      OP_SD        = 6'd11,
      OP_SUB       = 6'd12,
      OP_ADD       = 6'd13,
      OP_SLL       = 6'd14,
      OP_SLT       = 6'd15,
      OP_SLTU      = 6'd16,
      OP_XOR       = 6'd17,
      OP_SRA       = 6'd18,
      OP_SRL       = 6'd19,
      OP_OR        = 6'd20,
      OP_AND       = 6'd21,
      OP_ADDI      = 6'd22,
      OP_SLLI      = 6'd23,
      OP_SLTI      = 6'd24,
      OP_SLTIU     = 6'd25,
      OP_XORI      = 6'd26,
      OP_SRAI      = 6'd27,
      OP_SRLI      = 6'd28,
      OP_ORI       = 6'd29,
      OP_ANDI      = 6'd30,
      OP_SUBW      = 6'd31,
      OP_ADDW      = 6'd32,
      OP_SLLW      = 6'd33,
      OP_SRAW      = 6'd34,
      OP_SRLW      = 6'd35,
      OP_ADDIW     = 6'd36,
      OP_SLLIW     = 6'd37,
      OP_SRAIW     = 6'd38,
      OP_SRLIW     = 6'd39,
      OP_BEQ       = 6'd40,
      OP_BNE       = 6'd41,
      OP_BLT       = 6'd42,
      OP_BGE       = 6'd43,
      OP_BLTU      = 6'd44,
      OP_BGEU      = 6'd45,
      OP_FENCE_TSO = 6'd46,
      OP_PAUSE     = 6'd47,
      OP_FENCE     = 6'd48,
      OP_ECALL     = 6'd49,
      OP_EBREAK    = 6'd50,
      OP_LUI       = 6'd51,
      OP_AUIPC     = 6'd52,
      OP_JAL       = 6'd53,
      OP_JALR      = 6'd54
   } op_type;

   // Major opcodes, instruction bits 6 to 2.
   localparam logic [4:0] MAJ_LOAD      = 5'h00;
   localparam logic [4:0] MAJ_MISC_MEM  = 5'h03;
   localparam logic [4:0] MAJ_OP_IMM    = 5'h04;
   localparam logic [4:0] MAJ_AUIPC     = 5'h05;
   localparam logic [4:0] MAJ_OP_IMM_32 = 5'h06;
   localparam logic [4:0] MAJ_STORE     = 5'h08;
   localparam logic [4:0] MAJ_OP        = 5'h0C;
   localparam logic [4:0] MAJ_LUI       = 5'h0D;
   localparam logic [4:0] MAJ_OP_32     = 5'h0E;
   localparam logic [4:0] MAJ_BRANCH    = 5'h18;
   localparam logic [4:0] MAJ_JALR      = 5'h19;
   localparam logic [4:0] MAJ_JAL       = 5'h1B;
   localparam logic [4:0] MAJ_SYSTEM    = 5'h1C;

   // Whole words that are matched exactly.
   localparam logic [31:0] WORD_FENCE_TSO = 32'h8330000f;
   localparam logic [31:0] WORD_PAUSE     = 32'h0100000f;
   localparam logic [31:0] WORD_ECALL     = 32'h00000073;
   localparam logic [31:0] WORD_EBREAK    = 32'h00100073;

   localparam logic [6:0] FUNCT7_ALT     = 7'h20;
   localparam logic [6:0] FUNCT7_SRAI_MASK = 7'h7e;

   typedef struct packed {
      logic [31:0] immediate;
      logic [6:0]  upper_code;
      logic [2:0]  minor_code;
      logic [4:0]  src2_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  dest_reg;
      op_type      operation;
      logic [4:0]  major_opcode;
      status_type  status;
   } rsp_type;

   localparam int RspWidth      = $bits(rsp_type);
   localparam int RspTdataWidth = ((RspWidth + 7) / 8) * 8;

endpackage

// ===== design/rv64i_instruction_decoder_core.sv =====
// Top level of the RV64I instruction decoder: input stage, decode logic, result stage.
//
//   channel   dir   width   contents
//   req_*     in    32      instruction word
//   rsp_*     out   72      decoded fields
//
// An accepted word reaches rsp_* through the input register and the result register;
// one word can be accepted in every cycle while rsp_tready does not stall the output side.
// The latency is set by the input register and the result register around the
// single decode pass.
// Synchronous reset empties both stages.
// A stall on rsp_tready holds the result and propagates to req_tready only when
// both stages are full.
`include "assert_macros.svh"

module rv64i_instruction_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] instr_word
   input  logic [rv64d_pkg::InstrWidth-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status, [6:2] major_opcode, [12:7] operation, [17:13] dest_reg,
   // [22:18] src1_reg, [27:23] src2_reg, [30:28] minor_code,
   // [37:31] upper_code, [69:38] immediate, [71:70] zero
   output logic [rv64d_pkg::RspTdataWidth-1:0] rsp_tdata
);
   import rv64d_pkg::*;

   logic                  word_valid;
   logic                  word_ready;
   logic [InstrWidth-1:0] word;
   rsp_type               decoded;
   logic [RspWidth-1:0]   rsp_bits;
   rsp_type               rsp_view;

   rv64d_stage #(
      .Width(InstrWidth)
   ) u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .out_valid(word_valid),
      .out_ready(word_ready),
      .out_data (word)
   );

   rv64d_decode u_decode (
      .instr_word(word),
      .result    (decoded)
   );

   rv64d_stage #(
      .Width(RspWidth)
   ) u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (word_valid),
      .in_ready (word_ready),
      .in_data  (decoded),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_bits)
   );

   assign rsp_view  = rsp_type'(rsp_bits);
   assign rsp_tdata = {{(RspTdataWidth - RspWidth){1'b0}}, rsp_bits};

   `ASSERT_CLK(a_accept_fills_stage, (req_tvalid && req_tready) |=> word_valid,
      "accepted word did not reach the input stage")
   `ASSERT_CLK(a_ok_has_op, (rsp_tvalid && rsp_view.status == ST_OK) |->
      (rsp_view.operation != OP_INVALID), "valid word without an operation")
   `ASSERT_NEVER(a_bad_has_op, rsp_tvalid && rsp_view.status != ST_OK &&
      (rsp_view.operation != OP_INVALID || rsp_view.immediate != 32'b0),
      "rejected word carries an operation or immediate")
   `ASSERT_NEVER(a_compact_clear, rsp_tvalid && rsp_view.status == ST_COMPACT &&
      (rsp_view.major_opcode != 5'b0 || rsp_view.dest_reg != 5'b0),
      "compressed word carries fields")

endmodule

// ===== design/rv64d_stage.sv =====
// Register stage with valid/ready handshake that streams one item per cycle while out_ready is high.
module rv64d_stage #(
   parameter int Width = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [Width-1:0] data_ff;

   // The stage refills in the same cycle that its content is taken.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== design/rv64d_decode.sv =====
// Combinational field split, operation lookup and immediate build of one word.
module rv64d_decode (
   input  logic [rv64d_pkg::InstrWidth-1:0] instr_word,
   output rv64d_pkg::rsp_type               result
);
   import rv64d_pkg::*;

   logic [4:0]  maj;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic        sel20;
   logic        srai_sel;
   logic        known;
   op_type      op;
   logic [31:0] imm;

   assign maj      = instr_word[6:2];
   assign f3       = instr_word[14:12];
   assign f7       = instr_word[31:25];
   assign sel20    = (f7 == FUNCT7_ALT);
   assign srai_sel = ((f7 & FUNCT7_SRAI_MASK) == FUNCT7_ALT);

   always_comb begin
      op    = OP_INVALID;
      known = 1'b1;
      unique case (maj)
         MAJ_LOAD: begin
            unique case (f3)
               3'd0: op = OP_LB;
               3'd1: op = OP_LH;
               3'd2: op = OP_LW;
               3'd3: op = OP_LD;
               3'd4: op = OP_LBU;
               3'd5: op = OP_LHU;
               3'd6: op = OP_LWU;
               default: op = OP_INVALID;
            endcase
         end
         MAJ_STORE: begin
            unique case (f3)
               3'd0: op = OP_SB;
               3'd1: op = OP_SH;
               3'd2: op = OP_SW;
               3'd3: op = OP_SD;
               default: op = OP_INVALID;
            endcase
         end
         MAJ_BRANCH: begin
            unique case (f3)
               3'd0: op = OP_BEQ;
               3'd1: op = OP_BNE;
               3'd4: op = OP_BLT;
               3'd5: op = OP_BGE;
               3'd6: op = OP_BLTU;
               3'd7: op = OP_BGEU;
               default: op = OP_INVALID;
            endcase
         end
         MAJ_OP: begin
            unique case (f3)
               3'd0: op = sel20 ? OP_SUB : OP_ADD;
               3'd1: op = OP_SLL;
               3'd2: op = OP_SLT;
               3'd3: op = OP_SLTU;
               3'd4: op = OP_XOR;
               3'd5: op = sel20 ? OP_SRA : OP_SRL;
               3'd6: op = OP_OR;
               default: op = OP_AND;
            endcase
         end
         MAJ_OP_IMM: begin
            unique case (f3)
               3'd0: op = OP_ADDI;
               3'd1: op = OP_SLLI;
               3'd2: op = OP_SLTI;
               3'd3: op = OP_SLTIU;
               3'd4: op = OP_XORI;
               3'd5: op = srai_sel ? OP_SRAI : OP_SRLI;
               3'd6: op = OP_ORI;
               default: op = OP_ANDI;
            endcase
         end
         MAJ_OP_32: begin
            unique case (f3)
               3'd0: op = sel20 ? OP_SUBW : OP_ADDW;
               3'd1: op = OP_SLLW;
               3'd5: op = sel20 ? OP_SRAW : OP_SRLW;
               default: op = OP_INVALID;
            endcase
         end
         MAJ_OP_IMM_32: begin
            unique case (f3)
               3'd0: op = OP_ADDIW;
               3'd1: op = OP_SLLIW;
               3'd5: op = sel20 ? OP_SRAIW : OP_SRLIW;
               default: op = OP_INVALID;
            endcase
         end
         MAJ_MISC_MEM: begin
            if (instr_word == WORD_FENCE_TSO) begin
               op = OP_FENCE_TSO;
            end else if (instr_word == WORD_PAUSE) begin
               op = OP_PAUSE;
            end else if (f3 == 3'd0) begin
               op = OP_FENCE;
            end
         end
         MAJ_SYSTEM: begin
            if (instr_word == WORD_ECALL) begin
               op = OP_ECALL;
            end else if (instr_word == WORD_EBREAK) begin
               op = OP_EBREAK;
            end
         end
         MAJ_LUI:   op = OP_LUI;
         MAJ_AUIPC: op = OP_AUIPC;
         MAJ_JAL:   op = OP_JAL;
         MAJ_JALR:  op = OP_JALR;
         default:   known = 1'b0;
      endcase
   end

   always_comb begin
      unique case (maj)
         MAJ_LOAD, MAJ_OP_IMM, MAJ_OP_IMM_32, MAJ_JALR:
            imm = {{20{instr_word[31]}}, instr_word[31:20]};
         MAJ_STORE:
            imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         MAJ_LUI, MAJ_AUIPC:
            imm = {instr_word[31:12], 12'b0};
         MAJ_BRANCH:
            imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
         MAJ_JAL:
            imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};
         default:
            imm = 32'b0;
      endcase
   end

   // Fields are filled in as far as the word proves valid.
   always_comb begin
      result = '0;
      if (instr_word[1:0] != 2'b11) begin
         result.status = ST_COMPACT;
      end else if (!known) begin
         result.status       = ST_UNKNOWN;
         result.major_opcode = maj;
      end else begin
         result.major_opcode = maj;
         result.dest_reg     = instr_word[11:7];
         result.src1_reg     = instr_word[19:15];
         result.src2_reg     = instr_word[24:20];
         result.minor_code   = f3;
         result.upper_code   = f7;
         if (op == OP_INVALID) begin
            result.status = ST_UNDEF;
         end else begin
            result.status    = ST_OK;
            result.operation = op;
            result.immediate = imm;
         end
      end
   end

endmodule
